// ----- rtl/core/khr_pkg.sv -----
// khr_pkg: shared types and constants of the key-hold ramp command generator
// no dependencies; used by scoped names by every design module of the block but khr_checker
package khr_pkg;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_THROTTLE_LIMIT    = 3'd0,
        CFG_STEER_LIMIT       = 3'd1,
        CFG_RELEASE_TIMEOUT   = 3'd2,
        CFG_STEER_STEP_INTVL  = 3'd3,
        CFG_DECAY_INTVL       = 3'd4
    } cfg_idx_t;

    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 16;

    // reset values of the configuration registers
    localparam logic [7:0]  RST_THROTTLE_LIMIT   = 8'd100;
    localparam logic [6:0]  RST_STEER_LIMIT      = 7'd100;
    localparam logic [15:0] RST_RELEASE_TIMEOUT  = 16'd250;
    localparam logic [15:0] RST_STEER_STEP_INTVL = 16'd40;
    localparam logic [15:0] RST_DECAY_INTVL      = 16'd20;

    // key codes after case folding
    localparam logic [7:0] KEY_W       = 8'h77;
    localparam logic [7:0] KEY_A       = 8'h61;
    localparam logic [7:0] KEY_D       = 8'h64;
    localparam logic [7:0] KEY_SPACE   = 8'h20;
    localparam logic [7:0] KEY_Q       = 8'h71;
    localparam logic [7:0] UPPER_FIRST = 8'h41;
    localparam logic [7:0] UPPER_LAST  = 8'h5A;
    localparam logic [7:0] CASE_OFFSET = 8'h20;

    // slots of the held flags and key ages
    localparam int HELD_W     = 0;
    localparam int HELD_A     = 1;
    localparam int HELD_D     = 2;
    localparam int HELD_SPACE = 3;
    localparam int NUM_KEYS   = 4;

    typedef struct packed {
        logic [7:0]  throttle_limit;
        logic [6:0]  steer_limit;
        logic [15:0] release_timeout_ms;
        logic [15:0] steer_step_interval_ms;
        logic [15:0] decay_interval_ms;
    } cfg_t;

    typedef struct packed {
        logic       key_valid;
        logic [7:0] key_byte;
        logic [7:0] elapsed_ms;
    } item_t;

    typedef struct packed {
        logic [7:0]        throttle;
        logic signed [7:0] steering;
        logic              brake;
        logic              active;
    } result_t;

endpackage

// ----- rtl/core/khr_cfg_regs.sv -----
// khr_cfg_regs: configuration register file of the command generator
// depends on khr_pkg
module khr_cfg_regs (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write_en,
    input  logic [khr_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [khr_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    output khr_pkg::cfg_t                       cfg
);

    khr_pkg::cfg_t cfg_reg;
    khr_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write_en)
        begin
            unique case (khr_pkg::cfg_idx_t'(cfg_index))
                khr_pkg::CFG_THROTTLE_LIMIT:   cfg_next.throttle_limit = cfg_data[7:0];
                khr_pkg::CFG_STEER_LIMIT:      cfg_next.steer_limit = cfg_data[6:0];
                khr_pkg::CFG_RELEASE_TIMEOUT:  cfg_next.release_timeout_ms = cfg_data;
                khr_pkg::CFG_STEER_STEP_INTVL: cfg_next.steer_step_interval_ms = cfg_data;
                khr_pkg::CFG_DECAY_INTVL:      cfg_next.decay_interval_ms = cfg_data;
                default:                       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.throttle_limit         <= khr_pkg::RST_THROTTLE_LIMIT;
            cfg_reg.steer_limit            <= khr_pkg::RST_STEER_LIMIT;
            cfg_reg.release_timeout_ms     <= khr_pkg::RST_RELEASE_TIMEOUT;
            cfg_reg.steer_step_interval_ms <= khr_pkg::RST_STEER_STEP_INTVL;
            cfg_reg.decay_interval_ms      <= khr_pkg::RST_DECAY_INTVL;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- rtl/core/khr_core.sv -----
// khr_core: command state and the single-pass update for one polling request
// depends on khr_pkg
module khr_core #(
    parameter int AGE_BITS = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             fire,
    input  khr_pkg::item_t   item,
    input  khr_pkg::cfg_t    cfg,
    output khr_pkg::result_t result
);

    localparam int AW = AGE_BITS;
    localparam int CW = (AGE_BITS > khr_pkg::CFG_DATA_BITS) ? AGE_BITS
                                                            : khr_pkg::CFG_DATA_BITS;
    localparam int NK = khr_pkg::NUM_KEYS;

    logic [7:0]        thr_reg,        thr_next;
    logic signed [7:0] str_reg,        str_next;
    logic              brake_reg,      brake_next;
    logic              active_reg,     active_next;
    logic [NK-1:0]     held_reg,       held_next;
    logic [AW-1:0]     key_age_reg     [NK];
    logic [AW-1:0]     key_age_next    [NK];
    logic [AW-1:0]     step_age_reg,   step_age_next;
    logic [AW-1:0]     thr_dec_age_reg, thr_dec_age_next;
    logic [AW-1:0]     str_dec_age_reg, str_dec_age_next;

    function automatic logic [AW-1:0] age_add(input logic [AW-1:0] age,
                                              input logic [7:0] dt);
        logic [AW:0] sum;
        sum = {1'b0, age} + (AW+1)'(dt);
        return sum[AW] ? {AW{1'b1}} : sum[AW-1:0];
    endfunction

    function automatic logic age_gt(input logic [AW-1:0] age,
                                    input logic [15:0] lim);
        return CW'(age) > CW'(lim);
    endfunction

    always_comb
    begin
        logic [7:0]        key_lc;
        logic              is_w, is_a, is_d, is_sp, is_q;
        logic [8:0]        t_inc;
        logic signed [8:0] s9, lim9;
        logic [7:0]        thr1;
        logic signed [7:0] str1;
        logic              brake1;
        logic [NK-1:0]     held1;

        thr_next         = thr_reg;
        str_next         = str_reg;
        brake_next       = brake_reg;
        active_next      = active_reg;
        held_next        = held_reg;
        key_age_next     = key_age_reg;
        step_age_next    = step_age_reg;
        thr_dec_age_next = thr_dec_age_reg;
        str_dec_age_next = str_dec_age_reg;

        // fold upper case letters
        key_lc = item.key_byte;
        if (item.key_byte >= khr_pkg::UPPER_FIRST && item.key_byte <= khr_pkg::UPPER_LAST)
        begin
            key_lc = item.key_byte + khr_pkg::CASE_OFFSET;
        end
        is_w  = item.key_valid && (key_lc == khr_pkg::KEY_W);
        is_a  = item.key_valid && (key_lc == khr_pkg::KEY_A);
        is_d  = item.key_valid && (key_lc == khr_pkg::KEY_D);
        is_sp = item.key_valid && (key_lc == khr_pkg::KEY_SPACE);
        is_q  = item.key_valid && (key_lc == khr_pkg::KEY_Q);

        // advance all timers
        for (int i = 0; i < NK; i++)
        begin
            key_age_next[i] = age_add(key_age_reg[i], item.elapsed_ms);
        end
        step_age_next    = age_add(step_age_reg, item.elapsed_ms);
        thr_dec_age_next = age_add(thr_dec_age_reg, item.elapsed_ms);
        str_dec_age_next = age_add(str_dec_age_reg, item.elapsed_ms);

        // key action
        thr1   = thr_reg;
        str1   = str_reg;
        brake1 = brake_reg;
        held1  = held_reg;
        t_inc  = {1'b0, thr_reg} + 9'd1;
        s9     = {str_reg[7], str_reg};
        lim9   = $signed({2'b00, cfg.steer_limit});

        if (is_w)
        begin
            thr1 = (t_inc > {1'b0, cfg.throttle_limit}) ? cfg.throttle_limit : t_inc[7:0];
            key_age_next[khr_pkg::HELD_W] = '0;
            held1[khr_pkg::HELD_W] = 1'b1;
        end
        if (is_a || is_d)
        begin
            if (age_gt(step_age_next, cfg.steer_step_interval_ms))
            begin
                if (is_a)
                begin
                    s9   = s9 - 9'sd1;
                    str1 = (s9 < -lim9) ? 8'(-lim9) : s9[7:0];
                end
                else
                begin
                    s9   = s9 + 9'sd1;
                    str1 = (s9 > lim9) ? lim9[7:0] : s9[7:0];
                end
                step_age_next = '0;
            end
            if (is_a)
            begin
                key_age_next[khr_pkg::HELD_A] = '0;
                held1[khr_pkg::HELD_A] = 1'b1;
            end
            else
            begin
                key_age_next[khr_pkg::HELD_D] = '0;
                held1[khr_pkg::HELD_D] = 1'b1;
            end
        end
        if (is_sp)
        begin
            brake1 = 1'b1;
            key_age_next[khr_pkg::HELD_SPACE] = '0;
            held1[khr_pkg::HELD_SPACE] = 1'b1;
        end
        if (is_q)
        begin
            active_next = 1'b0;
        end

        // release keys that have aged out
        held_next = held1;
        for (int i = 0; i < NK; i++)
        begin
            if (held1[i] && age_gt(key_age_next[i], cfg.release_timeout_ms))
            begin
                held_next[i] = 1'b0;
            end
        end
        brake_next = brake1 && held_next[khr_pkg::HELD_SPACE];
        if (held1[khr_pkg::HELD_SPACE] == 1'b0)
        begin
            brake_next = brake1;
        end

        // throttle decay
        thr_next = thr1;
        if (!held_next[khr_pkg::HELD_W] && (thr1 != 8'd0) &&
            age_gt(thr_dec_age_next, cfg.decay_interval_ms))
        begin
            thr_next = thr1 - 8'd1;
            thr_dec_age_next = '0;
        end

        // steering return to center
        str_next = str1;
        if (!held_next[khr_pkg::HELD_A] && !held_next[khr_pkg::HELD_D] &&
            (str1 != 8'sd0) && age_gt(str_dec_age_next, cfg.decay_interval_ms))
        begin
            str_next = (str1 > 8'sd0) ? (str1 - 8'sd1) : (str1 + 8'sd1);
            str_dec_age_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg         <= '0;
            str_reg         <= '0;
            brake_reg       <= 1'b0;
            active_reg      <= 1'b1;
            held_reg        <= '0;
            step_age_reg    <= '0;
            thr_dec_age_reg <= '0;
            str_dec_age_reg <= '0;
            for (int i = 0; i < NK; i++)
            begin
                key_age_reg[i] <= '0;
            end
        end
        else if (fire && active_reg)
        begin
            thr_reg         <= thr_next;
            str_reg         <= str_next;
            brake_reg       <= brake_next;
            active_reg      <= active_next;
            held_reg        <= held_next;
            key_age_reg     <= key_age_next;
            step_age_reg    <= step_age_next;
            thr_dec_age_reg <= thr_dec_age_next;
            str_dec_age_reg <= str_dec_age_next;
        end
    end

    // once inactive the state is frozen and only reported
    always_comb
    begin
        if (active_reg)
        begin
            result.throttle = thr_next;
            result.steering = str_next;
            result.brake    = brake_next;
            result.active   = active_next;
        end
        else
        begin
            result.throttle = thr_reg;
            result.steering = str_reg;
            result.brake    = brake_reg;
            result.active   = active_reg;
        end
    end

endmodule

// ----- rtl/core/khr_out_queue.sv -----
// khr_out_queue: two-entry result queue, output register plus skid register
// depends on khr_pkg
module khr_out_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  khr_pkg::result_t push_data,
    input  logic             pop_ready,
    output logic             out_valid,
    output khr_pkg::result_t out_data,
    output logic             full
);

    logic             head_valid_reg, head_valid_next;
    logic             skid_valid_reg, skid_valid_next;
    khr_pkg::result_t head_reg,       head_next;
    khr_pkg::result_t skid_reg,       skid_next;
    logic             pop;

    assign pop = head_valid_reg && pop_ready;

    always_comb
    begin
        head_valid_next = head_valid_reg;
        skid_valid_next = skid_valid_reg;
        head_next       = head_reg;
        skid_next       = skid_reg;
        if (pop)
        begin
            if (skid_valid_reg)
            begin
                head_next       = skid_reg;
                skid_valid_next = push;
                skid_next       = push_data;
            end
            else
            begin
                head_valid_next = push;
                head_next       = push_data;
            end
        end
        else if (push)
        begin
            if (!head_valid_reg)
            begin
                head_valid_next = 1'b1;
                head_next       = push_data;
            end
            else
            begin
                skid_valid_next = 1'b1;
                skid_next       = push_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            head_valid_reg <= head_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
        skid_reg <= skid_next;
    end

    assign out_valid = head_valid_reg;
    assign out_data  = head_reg;
    assign full      = head_valid_reg && skid_valid_reg;

endmodule

// ----- rtl/core/key_hold_ramp_command_generator_unit.sv -----
// key_hold_ramp_command_generator_unit: top level of the key-hold ramp generator
// depends on khr_pkg, khr_cfg_regs, khr_core, khr_out_queue
//
// One request is one polling pass (optional key byte plus elapsed milliseconds)
// and gives exactly one result (throttle, steering, brake, active). A request
// is taken into an input register, updated against the command state and
// written to a two-entry result queue, so the unit takes one request per clock
// while the queue has room, and its result is shown from the queue's head
// register, which it enters from the input register directly or via the skid register. in_ready
// drops only while the input register holds a request and both queue entries
// are occupied, i.e. while the consumer stalls. Keys w/a/d/space/q (either case)
// ramp the throttle, step the steering, hold the brake and stop the unit; after
// q the state freezes and every later request reports it unchanged. All timers
// are AGE_BITS wide and saturate. Configuration writes take effect on the next
// clock and are meant to be done while no request is in flight.
module key_hold_ramp_command_generator_unit #(
    parameter int AGE_BITS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration write port
    input  logic                              cfg_write_en,
    input  logic [khr_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [khr_pkg::CFG_DATA_BITS-1:0] cfg_data,
    // request channel
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              key_valid,
    input  logic [7:0]                        key_byte,
    input  logic [7:0]                        elapsed_ms,
    // result channel
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [7:0]                        throttle_out,
    output logic signed [7:0]                 steering_out,
    output logic                              brake_out,
    output logic                              active_out
);

    khr_pkg::cfg_t    cfg;
    khr_pkg::item_t   s1_item_reg, s1_item_next;
    logic             s1_valid_reg, s1_valid_next;
    logic             q_full;
    logic             fire;
    logic             in_accept;
    khr_pkg::result_t core_result;
    khr_pkg::result_t out_data;

    // configuration registers
    khr_cfg_regs u_cfg_regs (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cfg          (cfg)
    );

    // input register: refills in the same cycle it hands a request on
    assign fire      = s1_valid_reg && !q_full;
    assign in_ready  = !s1_valid_reg || !q_full;
    assign in_accept = in_valid && in_ready;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        s1_item_next  = s1_item_reg;
        if (in_accept)
        begin
            s1_valid_next          = 1'b1;
            s1_item_next.key_valid = key_valid;
            s1_item_next.key_byte  = key_byte;
            s1_item_next.elapsed_ms = elapsed_ms;
        end
        else if (fire)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_item_reg <= s1_item_next;
    end

    // command state and the per-request update
    khr_core #(
        .AGE_BITS (AGE_BITS)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .item   (s1_item_reg),
        .cfg    (cfg),
        .result (core_result)
    );

    // result queue decouples out_ready from the update
    khr_out_queue u_out_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (fire),
        .push_data (core_result),
        .pop_ready (out_ready),
        .out_valid (out_valid),
        .out_data  (out_data),
        .full      (q_full)
    );

    assign throttle_out = out_data.throttle;
    assign steering_out = out_data.steering;
    assign brake_out    = out_data.brake;
    assign active_out   = out_data.active;

endmodule

// ----- rtl/core/khr_checker.sv -----
// khr_checker: port-level checks of the key-hold ramp generator, bound to the top
// depends on key_hold_ramp_command_generator_unit
module khr_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_ready,
    input  logic                              out_valid,
    input  logic                              out_ready,
    input  logic [7:0]                        throttle_out,
    input  logic signed [7:0]                 steering_out,
    input  logic                              brake_out,
    input  logic                              active_out
);

    logic              quit_seen_reg;
    logic [7:0]        quit_thr_reg;
    logic signed [7:0] quit_str_reg;
    logic              quit_brake_reg;

    // capture the state reported by the first result after quit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quit_seen_reg <= 1'b0;
        end
        else if (out_valid && out_ready && !active_out && !quit_seen_reg)
        begin
            quit_seen_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_valid && out_ready && !active_out && !quit_seen_reg)
        begin
            quit_thr_reg   <= throttle_out;
            quit_str_reg   <= steering_out;
            quit_brake_reg <= brake_out;
        end
    end

    // stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(throttle_out) &&
        $stable(steering_out) && $stable(brake_out) && $stable(active_out))
        else $error("stalled result changed");

    // steering never leaves the symmetric range
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> steering_out != 8'sh80)
        else $error("steering out of range");

    // backpressure only while a result waits
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("request stalled with no pending result");

    // after quit every result repeats the frozen state
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && quit_seen_reg |-> !active_out && throttle_out == quit_thr_reg &&
        steering_out == quit_str_reg && brake_out == quit_brake_reg)
        else $error("state changed after quit");

endmodule

bind key_hold_ramp_command_generator_unit khr_checker u_khr_checker (.*);

// ----- tb/khr_pass_checker.sv -----
`timescale 1ns / 1ps
// khr_pass_checker: tracks config writes, predicts each polling result and checks it
// depends on khr_pkg; sits beside the generator and only observes its ports
module khr_pass_checker #(
    parameter int AGE_BITS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write_en,
    input  logic [khr_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [khr_pkg::CFG_DATA_BITS-1:0] cfg_data,
    input  logic                              in_valid,
    input  logic                              in_ready,
    input  logic                              key_valid,
    input  logic [7:0]                        key_byte,
    input  logic [7:0]                        elapsed_ms,
    input  logic                              out_valid,
    input  logic                              out_ready,
    input  logic [7:0]                        throttle_out,
    input  logic signed [7:0]                 steering_out,
    input  logic                              brake_out,
    input  logic                              active_out,
    output int                                fail_count,
    output int                                pending
);

    typedef logic [AGE_BITS-1:0] age_t;

    logic [7:0]                   throttle_limit;
    logic [6:0]                   steer_limit;
    logic [15:0]                  release_ms;
    logic [15:0]                  step_interval_ms;
    logic [15:0]                  decay_interval_ms;

    int                           throttle_lvl;
    int                           steer_lvl;
    logic                         brake_lvl;
    logic                         active_lvl;
    logic [khr_pkg::NUM_KEYS-1:0] held;
    age_t                         key_age [khr_pkg::NUM_KEYS];
    age_t                         step_age;
    age_t                         throttle_decay_age;
    age_t                         steer_decay_age;

    khr_pkg::result_t             command_q [$];

    function automatic age_t age_advance(input age_t age, input logic [7:0] dt);
        logic [AGE_BITS:0] sum;
        sum = {1'b0, age} + (AGE_BITS+1)'(dt);
        return sum[AGE_BITS] ? {AGE_BITS{1'b1}} : sum[AGE_BITS-1:0];
    endfunction

    function automatic void clear_state();
        throttle_limit     = khr_pkg::RST_THROTTLE_LIMIT;
        steer_limit        = khr_pkg::RST_STEER_LIMIT;
        release_ms         = khr_pkg::RST_RELEASE_TIMEOUT;
        step_interval_ms   = khr_pkg::RST_STEER_STEP_INTVL;
        decay_interval_ms  = khr_pkg::RST_DECAY_INTVL;
        throttle_lvl       = 0;
        steer_lvl          = 0;
        brake_lvl          = 1'b0;
        active_lvl         = 1'b1;
        held               = '0;
        for (int i = 0; i < khr_pkg::NUM_KEYS; i++)
            key_age[i] = '0;
        step_age           = '0;
        throttle_decay_age = '0;
        steer_decay_age    = '0;
    endfunction

    // one polling pass against the command state
    function automatic khr_pkg::result_t command_pass(input logic kv, input logic [7:0] kb,
                                                      input logic [7:0] dt);
        logic [7:0]       key;
        int               tl;
        int               sl;
        int               nxt;
        int               slot;
        khr_pkg::result_t r;
        if (active_lvl)
        begin
            tl = int'(throttle_limit);
            sl = int'(steer_limit);
            for (int i = 0; i < khr_pkg::NUM_KEYS; i++)
                key_age[i] = age_advance(key_age[i], dt);
            step_age           = age_advance(step_age, dt);
            throttle_decay_age = age_advance(throttle_decay_age, dt);
            steer_decay_age    = age_advance(steer_decay_age, dt);

            key = kb;
            if (kv)
            begin
                if (key >= khr_pkg::UPPER_FIRST && key <= khr_pkg::UPPER_LAST)
                    key = key + khr_pkg::CASE_OFFSET;
                if (key == khr_pkg::KEY_W)
                begin
                    throttle_lvl = (throttle_lvl + 1 > tl) ? tl : throttle_lvl + 1;
                    key_age[khr_pkg::HELD_W] = '0;
                    held[khr_pkg::HELD_W]    = 1'b1;
                end
                else if (key == khr_pkg::KEY_A || key == khr_pkg::KEY_D)
                begin
                    slot = (key == khr_pkg::KEY_A) ? khr_pkg::HELD_A : khr_pkg::HELD_D;
                    if (step_age > step_interval_ms)
                    begin
                        if (key == khr_pkg::KEY_A)
                        begin
                            nxt       = steer_lvl - 1;
                            steer_lvl = (nxt < -sl) ? -sl : nxt;
                        end
                        else
                        begin
                            nxt       = steer_lvl + 1;
                            steer_lvl = (nxt > sl) ? sl : nxt;
                        end
                        step_age = '0;
                    end
                    key_age[slot] = '0;
                    held[slot]    = 1'b1;
                end
                else if (key == khr_pkg::KEY_SPACE)
                begin
                    brake_lvl                    = 1'b1;
                    key_age[khr_pkg::HELD_SPACE] = '0;
                    held[khr_pkg::HELD_SPACE]    = 1'b1;
                end
                else if (key == khr_pkg::KEY_Q)
                begin
                    active_lvl = 1'b0;
                end
            end

            // timed release, then decay
            for (int i = 0; i < khr_pkg::NUM_KEYS; i++)
            begin
                if (held[i] && key_age[i] > release_ms)
                begin
                    held[i] = 1'b0;
                    if (i == khr_pkg::HELD_SPACE)
                        brake_lvl = 1'b0;
                end
            end
            if (!held[khr_pkg::HELD_W] && throttle_lvl > 0 &&
                throttle_decay_age > decay_interval_ms)
            begin
                throttle_lvl       = throttle_lvl - 1;
                throttle_decay_age = '0;
            end
            if (!held[khr_pkg::HELD_A] && !held[khr_pkg::HELD_D] && steer_lvl != 0 &&
                steer_decay_age > decay_interval_ms)
            begin
                steer_lvl       = steer_lvl + ((steer_lvl > 0) ? -1 : 1);
                steer_decay_age = '0;
            end
            if (steer_lvl < -128)
                steer_lvl = -128;
            else if (steer_lvl > 127)
                steer_lvl = 127;
        end
        r.throttle = throttle_lvl[7:0];
        r.steering = steer_lvl[7:0];
        r.brake    = brake_lvl;
        r.active   = active_lvl;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        khr_pkg::result_t want;
        if (!rst_n)
        begin
            clear_state();
            command_q.delete();
            fail_count = 0;
            pending    = 0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                case (cfg_index)
                    khr_pkg::CFG_THROTTLE_LIMIT:   throttle_limit    = cfg_data[7:0];
                    khr_pkg::CFG_STEER_LIMIT:      steer_limit       = cfg_data[6:0];
                    khr_pkg::CFG_RELEASE_TIMEOUT:  release_ms        = cfg_data;
                    khr_pkg::CFG_STEER_STEP_INTVL: step_interval_ms  = cfg_data;
                    khr_pkg::CFG_DECAY_INTVL:      decay_interval_ms = cfg_data;
                    default: ;
                endcase
            end
            if (out_valid && out_ready)
            begin
                if (command_q.size() == 0)
                begin
                    $error("result with no request outstanding");
                    fail_count++;
                end
                else
                begin
                    want = command_q.pop_front();
                    if (throttle_out !== want.throttle)
                    begin
                        $error("throttle_out expected %0d got %0d", want.throttle,
                               throttle_out);
                        fail_count++;
                    end
                    if (steering_out !== want.steering)
                    begin
                        $error("steering_out expected %0d got %0d", want.steering,
                               steering_out);
                        fail_count++;
                    end
                    if (brake_out !== want.brake)
                    begin
                        $error("brake_out expected %0d got %0d", want.brake, brake_out);
                        fail_count++;
                    end
                    if (active_out !== want.active)
                    begin
                        $error("active_out expected %0d got %0d", want.active, active_out);
                        fail_count++;
                    end
                end
            end
            if (in_valid && in_ready)
                command_q.push_back(command_pass(key_valid, key_byte, elapsed_ms));
            pending = command_q.size();
        end
    end

endmodule

// ----- tb/key_hold_ramp_command_generator_unit_tb.sv -----
`timescale 1ns / 1ps
// key_hold_ramp_command_generator_unit_tb: stimulus and verdict for the key-hold ramp generator
// depends on khr_pkg, key_hold_ramp_command_generator_unit and khr_pass_checker
module key_hold_ramp_command_generator_unit_tb;

    // cycles without any handshake before the run is declared hung
    localparam int HANG_LIMIT = 2000;

    logic                              clk;
    logic                              rst_n;
    logic                              cfg_write_en;
    logic [khr_pkg::CFG_IDX_BITS-1:0]  cfg_index;
    logic [khr_pkg::CFG_DATA_BITS-1:0] cfg_data;
    logic                              in_valid;
    logic                              in_ready;
    logic                              key_valid;
    logic [7:0]                        key_byte;
    logic [7:0]                        elapsed_ms;
    logic                              out_valid;
    logic                              out_ready;
    logic [7:0]                        throttle_out;
    logic signed [7:0]                 steering_out;
    logic                              brake_out;
    logic                              active_out;

    int                                fail_count;
    int                                pending;
    int                                passes_sent;
    int                                hang_count;
    // no idling on either side while set
    logic                              calm;

    key_hold_ramp_command_generator_unit u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .key_valid    (key_valid),
        .key_byte     (key_byte),
        .elapsed_ms   (elapsed_ms),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .throttle_out (throttle_out),
        .steering_out (steering_out),
        .brake_out    (brake_out),
        .active_out   (active_out)
    );

    khr_pass_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .key_valid    (key_valid),
        .key_byte     (key_byte),
        .elapsed_ms   (elapsed_ms),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .throttle_out (throttle_out),
        .steering_out (steering_out),
        .brake_out    (brake_out),
        .active_out   (active_out),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #4 clk = ~clk;

    // result side back-pressure on about 11 percent of clocks, none while calm
    always @(posedge clk)
    begin
        out_ready <= calm || ($urandom_range(99) >= 11);
    end

    // hang watchdog: reset or any handshake on either channel restarts the count
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            hang_count <= 0;
        else
            hang_count <= hang_count + 1;
        if (hang_count >= HANG_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // one polling request; valid stays up until the generator takes it
    task automatic send_pass(input logic kv, input logic [7:0] kb, input logic [7:0] dt);
        while (!calm && $urandom_range(99) < 11)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        key_valid  <= kv;
        key_byte   <= kb;
        elapsed_ms <= dt;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        passes_sent++;
    endtask

    // drain, let the pipe settle, then rewrite every register
    // upper data bits of the two limit writes are random to exercise the register masks
    task automatic program_setting(input int tl, input int sl, input int rel_ms,
                                   input int step_ms, input int dec_ms);
        logic [15:0] junk;
        junk = 16'($urandom);
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (4) @(posedge clk);
        cfg_write_en <= 1'b1;
        cfg_index    <= khr_pkg::CFG_THROTTLE_LIMIT;
        cfg_data     <= {junk[15:8], 8'(tl)};
        @(posedge clk);
        cfg_index    <= khr_pkg::CFG_STEER_LIMIT;
        cfg_data     <= {junk[15:7], 7'(sl)};
        @(posedge clk);
        cfg_index    <= khr_pkg::CFG_RELEASE_TIMEOUT;
        cfg_data     <= 16'(rel_ms);
        @(posedge clk);
        cfg_index    <= khr_pkg::CFG_STEER_STEP_INTVL;
        cfg_data     <= 16'(step_ms);
        @(posedge clk);
        cfg_index    <= khr_pkg::CFG_DECAY_INTVL;
        cfg_data     <= 16'(dec_ms);
        @(posedge clk);
        cfg_write_en <= 1'b0;
    endtask

    function automatic logic [7:0] pick_key();
        case ($urandom_range(3))
            0:       return khr_pkg::KEY_W;
            1:       return khr_pkg::KEY_A;
            2:       return khr_pkg::KEY_D;
            default: return khr_pkg::KEY_SPACE;
        endcase
    endfunction

    // letters go out in upper case half the time
    function automatic logic [7:0] vary_case(input logic [7:0] k);
        if (k != khr_pkg::KEY_SPACE && $urandom_range(1) == 1)
            return k - khr_pkg::CASE_OFFSET;
        return k;
    endfunction

    // quit stays out of the random part, it would freeze everything after it
    function automatic logic [7:0] no_quit(input logic [7:0] k);
        if (k == khr_pkg::KEY_Q || k == khr_pkg::KEY_Q - khr_pkg::CASE_OFFSET)
            return k ^ 8'h01;
        return k;
    endfunction

    // mostly short gaps so held keys stay held, now and then a long one
    function automatic logic [7:0] short_gap();
        if ($urandom_range(9) < 8)
            return 8'($urandom_range(50));
        return 8'($urandom_range(255));
    endfunction

    // random polling traffic: key-hold bursts, idle gaps and raw noise
    task automatic run_phase(input int count);
        int          stop_at;
        int          mode;
        logic [7:0]  hold;
        stop_at = passes_sent + count;
        while (passes_sent < stop_at)
        begin
            mode = $urandom_range(9);
            if (mode < 6)
            begin
                hold = pick_key();
                repeat ($urandom_range(3, 20))
                begin
                    if ($urandom_range(9) < 8)
                        send_pass(1'b1, vary_case(hold), short_gap());
                    else
                        send_pass(1'b1, vary_case(pick_key()), short_gap());
                end
            end
            else if (mode < 8)
            begin
                // no key: ages run, keys drop out and levels decay
                repeat ($urandom_range(2, 10))
                    send_pass(1'b0, 8'($urandom), 8'($urandom));
            end
            else
            begin
                repeat ($urandom_range(1, 6))
                    send_pass(1'($urandom), no_quit(8'($urandom)), 8'($urandom));
            end
        end
    endtask

    initial
    begin
        calm         <= 1'b0;
        rst_n        <= 1'b0;
        cfg_write_en <= 1'b0;
        cfg_index    <= khr_pkg::CFG_THROTTLE_LIMIT;
        cfg_data     <= '0;
        in_valid     <= 1'b0;
        key_valid    <= 1'b0;
        key_byte     <= '0;
        elapsed_ms   <= '0;
        passes_sent  = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed passes at the reset setting
        send_pass(1'b0, 8'hFF, 8'd0);                                  // ignored byte
        send_pass(1'b1, 8'h00, 8'd255);                                // unknown key
        send_pass(1'b1, khr_pkg::KEY_W, 8'd0);
        send_pass(1'b1, khr_pkg::KEY_W - khr_pkg::CASE_OFFSET, 8'd1);  // upper-case ramp
        send_pass(1'b0, khr_pkg::KEY_W, 8'd5);                         // w, no key_valid
        send_pass(1'b1, khr_pkg::KEY_A, 8'd41);                        // interval passed
        send_pass(1'b1, khr_pkg::KEY_A - khr_pkg::CASE_OFFSET, 8'd10); // too soon to step
        send_pass(1'b1, khr_pkg::KEY_D, 8'd255);
        send_pass(1'b1, khr_pkg::KEY_D - khr_pkg::CASE_OFFSET, 8'd0);
        send_pass(1'b1, khr_pkg::KEY_SPACE, 8'd3);
        send_pass(1'b1, khr_pkg::UPPER_FIRST - 8'd1, 8'd7);            // below fold range
        send_pass(1'b1, khr_pkg::UPPER_LAST + 8'd1, 8'd7);             // above fold range
        send_pass(1'b1, khr_pkg::UPPER_LAST, 8'd7);                    // folds to unused key
        send_pass(1'b1, khr_pkg::KEY_W | 8'h80, 8'd9);                 // high bit set
        repeat (3) send_pass(1'b0, 8'h00, 8'd255);                     // release all, decay
        repeat (4) send_pass(1'b1, khr_pkg::KEY_W, 8'd0);
        send_pass(1'b1, khr_pkg::KEY_A, 8'd50);
        send_pass(1'b1, khr_pkg::KEY_A, 8'd50);
        send_pass(1'b0, 8'h00, 8'd255);
        send_pass(1'b1, khr_pkg::KEY_SPACE, 8'd0);
        send_pass(1'b0, 8'h00, 8'd251);                                // brake released

        // top limits
        program_setting(255, 127, 250, 40, 20);
        run_phase(118);
        // keys never released, no decay, a steer step needs only a nonzero step age; no idling here
        program_setting(200, 90, 65535, 0, 65535);
        calm <= 1'b1;
        run_phase(118);
        // limits dropped under the levels reached above
        program_setting(5, 3, 300, 15, 25);
        calm <= 1'b0;
        run_phase(118);
        // smallest limits, zero timeouts and intervals
        program_setting(1, 1, 0, 0, 0);
        run_phase(118);
        // zero limits pin both levels at zero
        program_setting(0, 0, 30, 10, 10);
        run_phase(118);
        program_setting($urandom_range(1, 255), $urandom_range(1, 127),
                        $urandom_range(400), $urandom_range(60), $urandom_range(60));
        run_phase(118);
        program_setting($urandom_range(1, 255), $urandom_range(1, 127),
                        $urandom_range(400), $urandom_range(60), $urandom_range(60));
        run_phase(118);

        // quit, with release and decay still due on that pass, then frozen state
        send_pass(1'b1, khr_pkg::KEY_W, 8'd3);
        send_pass(1'b1, khr_pkg::KEY_Q - khr_pkg::CASE_OFFSET, 8'd255);
        send_pass(1'b1, khr_pkg::KEY_Q, 8'd255);
        send_pass(1'b1, khr_pkg::KEY_W, 8'd10);
        send_pass(1'b1, khr_pkg::KEY_A, 8'd255);
        repeat (3) send_pass(1'($urandom), 8'($urandom), 8'($urandom));

        // drain outstanding results, then a short settle
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (8) @(posedge clk);

        if (fail_count == 0 && pending == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
